>>> src/dssg_pkg.sv
`default_nettype none

package dssg_pkg;

  // Sine table geometry (depth is a power of two, address is the phase MSBs)
  localparam int unsigned SINE_DEPTH = 1024;
  localparam int unsigned ROM_AW     = $clog2(SINE_DEPTH);
  localparam int unsigned SINE_W     = 16;
  localparam real         TWO_PI     = 6.283185307179586476925;
  localparam real         SINE_PEAK  = 32767.0;
  localparam real         SINE_STEP  = TWO_PI / SINE_DEPTH;

  // Run length
  localparam int unsigned MAX_SAMPLES = 4096;
  localparam int unsigned IDX_W       = $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_W       = IDX_W + 1;

  // Field and register widths
  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned ENV_W      = 32;
  localparam int unsigned DECAY_W    = 17;
  localparam int unsigned DECAY_FRAC = 16;
  localparam int unsigned AMP_W      = 16;
  localparam int unsigned AMP_SHIFT  = 16;
  localparam int unsigned SCOUNT_W   = 13;
  localparam int unsigned SAMPLE_W   = 18;
  localparam int unsigned PROD_W     = ENV_W + SINE_W + 1;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Decay factor of exactly one
  localparam logic [DECAY_W-1:0] DECAY_ONE = DECAY_W'(1 << DECAY_FRAC);

  // Register reset values
  localparam logic [PHASE_W-1:0]  RST_PHASE_STEP   = PHASE_W'(42949673);
  localparam logic [DECAY_W-1:0]  RST_DECAY        = DECAY_W'(65470);
  localparam logic [AMP_W-1:0]    RST_AMPLITUDE    = AMP_W'(4096);
  localparam logic [SCOUNT_W-1:0] RST_SAMPLE_COUNT = SCOUNT_W'(1001);
  localparam logic [ENV_W-1:0]    RST_ENVELOPE     = ENV_W'(4096) << AMP_SHIFT;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP   = 2'd0,
    REG_DECAY        = 2'd1,
    REG_AMPLITUDE    = 2'd2,
    REG_SAMPLE_COUNT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [PHASE_W-1:0]  phase_step;
    logic [DECAY_W-1:0]  decay_factor;
    logic [AMP_W-1:0]    amplitude;
    logic [SCOUNT_W-1:0] sample_count;
  } cfg_t;

  // Per-sample context handed from the state update to the sample datapath
  typedef struct packed {
    logic [ENV_W-1:0]  envelope;
    logic [ROM_AW-1:0] addr;
    logic [IDX_W-1:0]  idx;
    logic              last;
  } ctx_t;

  typedef logic signed [SINE_W-1:0] sine_rom_t [SINE_DEPTH];

  // round(32767*sin(2*pi*k/depth)), half away from zero; built at elaboration
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    real       ang;
    real       val;
    int        mag;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      ang = SINE_STEP * real'(k);
      val = SINE_PEAK * $sin(ang);
      if (val >= 0.0) begin
        mag = $rtoi(val + 0.5);
      end else begin
        mag = -$rtoi(0.5 - val);
      end
      rom[k] = SINE_W'(mag);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

>>> src/dssg_state.sv
`default_nettype none

module dssg_state (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire dssg_pkg::cfg_t cfg_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic           restart_i,
  output dssg_pkg::ctx_t      ctx_o,
  output logic                ctx_valid_o,
  input  wire logic           ctx_ready_i
);
  import dssg_pkg::*;

  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [ENV_W-1:0]   env_q, env_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  ctx_t               ctx_q, ctx_d;
  logic               ctx_valid_q;

  logic                     accept;
  logic [ENV_W-1:0]         env_start;
  logic [PHASE_W-1:0]       phase_eff;
  logic [ENV_W-1:0]         env_eff;
  logic [IDX_W-1:0]         idx_eff;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         idx_inc;
  logic [DECAY_W-1:0]       decay;
  logic [ENV_W+DECAY_W-1:0] decay_prod;
  logic                     last;

  // Context stage takes a new transaction when empty or draining
  assign in_ready_o  = !ctx_valid_q || ctx_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign ctx_o       = ctx_q;
  assign ctx_valid_o = ctx_valid_q;

  assign env_start = ENV_W'({cfg_i.amplitude, {AMP_SHIFT{1'b0}}});

  // Restart applies before the sample is produced
  always_comb begin
    if (restart_i) begin
      phase_eff = '0;
      env_eff   = env_start;
      idx_eff   = '0;
    end else begin
      phase_eff = phase_q;
      env_eff   = env_q;
      idx_eff   = idx_q;
    end
  end

  // Clamp run length to 1..MAX_SAMPLES and decay to at most one
  always_comb begin
    if (cfg_i.sample_count == '0) begin
      count = CNT_W'(1);
    end else if (cfg_i.sample_count > SCOUNT_W'(MAX_SAMPLES)) begin
      count = CNT_W'(MAX_SAMPLES);
    end else begin
      count = CNT_W'(cfg_i.sample_count);
    end
    if (cfg_i.decay_factor > DECAY_ONE) begin
      decay = DECAY_ONE;
    end else begin
      decay = cfg_i.decay_factor;
    end
  end

  assign idx_inc    = {1'b0, idx_eff} + CNT_W'(1);
  assign last       = (idx_inc >= count);
  assign decay_prod = (ENV_W+DECAY_W)'(env_eff) * (ENV_W+DECAY_W)'(decay);

  // Next state: a new run after the last sample, otherwise advance
  always_comb begin
    if (last) begin
      phase_d = '0;
      env_d   = env_start;
      idx_d   = '0;
    end else begin
      phase_d = phase_eff + cfg_i.phase_step;
      env_d   = decay_prod[ENV_W+DECAY_FRAC-1:DECAY_FRAC];
      idx_d   = idx_inc[IDX_W-1:0];
    end
    ctx_d.envelope = env_eff;
    ctx_d.addr     = phase_eff[PHASE_W-1 -: ROM_AW];
    ctx_d.idx      = idx_eff;
    ctx_d.last     = last;
  end

  // Generator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      env_q   <= RST_ENVELOPE;
      idx_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      env_q   <= env_d;
      idx_q   <= idx_d;
    end
  end

  // Context register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      ctx_valid_q <= accept;
    end
  end

  // Context payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctx_q <= ctx_d;
    end
  end

`ifndef ASSERT_OFF
  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last |=> (idx_q == '0) && (phase_q == '0))
    else $error("run did not restart after last sample");

  a_idx_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !restart_i && !last |=> idx_q == IDX_W'($past(idx_q) + 1'b1))
    else $error("sample index did not advance by one");

  a_ctx_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctx_valid_o && !ctx_ready_i |=> ctx_valid_o && $stable(ctx_q))
    else $error("stalled context changed");
`endif

endmodule

`default_nettype wire

>>> src/dssg_sample.sv
`default_nettype none

module dssg_sample (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dssg_pkg::ctx_t        ctx_i,
  input  wire logic                  ctx_valid_i,
  output logic                       ctx_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic signed [dssg_pkg::SAMPLE_W-1:0] sample_o,
  output logic [dssg_pkg::IDX_W-1:0] sample_index_o,
  output logic                       last_o
);
  import dssg_pkg::*;

  // Table stage
  logic                     tab_valid_q;
  logic signed [SINE_W-1:0] sine_q;
  logic [ENV_W-1:0]         env_q;
  logic [IDX_W-1:0]         tab_idx_q;
  logic                     tab_last_q;

  // Output stage
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;
  logic [IDX_W-1:0]           out_idx_q;
  logic                       out_last_q;

  logic                     out_en;
  logic signed [PROD_W-1:0] prod;

  assign out_en      = !out_valid_q || out_ready_i;
  assign ctx_ready_o = !tab_valid_q || out_en;

  // envelope * sine >> 31; |result| stays below 2^16 so no clamp is reached
  assign prod     = $signed({1'b0, env_q}) * sine_q;
  assign sample_d = prod[PROD_W-1 -: SAMPLE_W];

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctx_ready_o) begin
        tab_valid_q <= ctx_valid_i;
      end
      if (out_en) begin
        out_valid_q <= tab_valid_q;
      end
    end
  end

  // Sine table read
  always_ff @(posedge clk_i) begin
    if (ctx_ready_o && ctx_valid_i) begin
      sine_q     <= SINE_ROM[ctx_i.addr];
      env_q      <= ctx_i.envelope;
      tab_idx_q  <= ctx_i.idx;
      tab_last_q <= ctx_i.last;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (out_en && tab_valid_q) begin
      sample_q   <= sample_d;
      out_idx_q  <= tab_idx_q;
      out_last_q <= tab_last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_o       = sample_q;
  assign sample_index_o = out_idx_q;
  assign last_o         = out_last_q;

`ifndef ASSERT_OFF
  a_ctx_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctx_valid_i && ctx_ready_o |=> tab_valid_q)
    else $error("accepted context lost in table stage");

  a_sample_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sample_q <= 18'sd65536) && (sample_q >= -18'sd65536))
    else $error("sample outside envelope-times-sine range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tab_valid_q && !ctx_ready_o |-> out_valid_o && !out_ready_i)
    else $error("table stage stalled without output backpressure");
`endif

endmodule

`default_nettype wire

>>> src/damped_sine_sample_generator_unit.sv
// Channel  | Handshake                 | Payload
// ---------+---------------------------+------------------------------------
// input    | in_valid_i / in_ready_o   | restart_i
// output   | out_valid_o / out_ready_i | sample_o, sample_index_o, last_o
// config   | cfg_we_i (no wait)        | cfg_idx_i, cfg_data_i
//
// One transaction per cycle sustained while out_ready_i stays high; three register
// stages (state update, sine table read, multiply into result reg) carry each
// input transaction to a sample on the outputs.
// The phase/envelope/index update closes its loop through the state registers: add plus 32x17 mult.
// Reset loads the default registers and starts a run at index 0.
// Output backpressure stalls stage by stage; bubbles are still filled.
`default_nettype none

module damped_sine_sample_generator_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [dssg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [dssg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              restart_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [dssg_pkg::SAMPLE_W-1:0]   sample_o,
  output logic [dssg_pkg::IDX_W-1:0]             sample_index_o,
  output logic                                   last_o
);
  import dssg_pkg::*;

  cfg_t cfg_q;
  ctx_t ctx;
  logic ctx_valid;
  logic ctx_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_step   <= RST_PHASE_STEP;
      cfg_q.decay_factor <= RST_DECAY;
      cfg_q.amplitude    <= RST_AMPLITUDE;
      cfg_q.sample_count <= RST_SAMPLE_COUNT;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PHASE_STEP:   cfg_q.phase_step   <= cfg_data_i[PHASE_W-1:0];
        REG_DECAY:        cfg_q.decay_factor <= cfg_data_i[DECAY_W-1:0];
        REG_AMPLITUDE:    cfg_q.amplitude    <= cfg_data_i[AMP_W-1:0];
        REG_SAMPLE_COUNT: cfg_q.sample_count <= cfg_data_i[SCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  dssg_state u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .restart_i   (restart_i),
    .ctx_o       (ctx),
    .ctx_valid_o (ctx_valid),
    .ctx_ready_i (ctx_ready)
  );

  dssg_sample u_sample (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctx_i          (ctx),
    .ctx_valid_i    (ctx_valid),
    .ctx_ready_o    (ctx_ready),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_o       (sample_o),
    .sample_index_o (sample_index_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire
